// ===== hw/rtl/lsrp_pkg.sv =====
// shared types, constants and the scan descriptor table of the scan record parser
package lsrp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned IDX_W       = 3;
   localparam int unsigned QUALITY_W   = 6;
   localparam int unsigned ANGLE_W     = 15;
   localparam int unsigned DISTANCE_W  = 16;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned PAYLOAD_W   = QUALITY_W + ANGLE_W + DISTANCE_W;
   localparam int unsigned RSP_DATA_W  = ((PAYLOAD_W + 7) / 8) * 8;

   localparam int unsigned DESC_LAST   = 6;   // index of the last descriptor byte
   localparam int unsigned RECORD_LAST = 4;   // index of the last record byte
   localparam int unsigned RECORD_BUF  = 4;   // record bytes held before the last arrives

   typedef enum logic [1:0] {
      PHASE_DESC = 2'd0,
      PHASE_REC  = 2'd1,
      PHASE_HALT = 2'd2
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE   = 2'd0,
      KIND_BAD_DESC = 2'd1,
      KIND_NO_START = 2'd2,
      KIND_REV_DONE = 2'd3
   } kind_type;

   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic [QUALITY_W-1:0]  quality;
      logic [ANGLE_W-1:0]    angle_q6;
      logic [DISTANCE_W-1:0] distance_q2;
   } result_type;

   // expected scan response descriptor, one byte per index
   function automatic logic [BYTE_W-1:0] desc_byte(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         3'd0:    b = 8'hA5;
         3'd1:    b = 8'h5A;
         3'd2:    b = 8'h05;
         3'd3:    b = 8'h00;
         3'd4:    b = 8'h00;
         3'd5:    b = 8'h40;
         default: b = 8'h81;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/lsrp_parser.sv =====
// descriptor check, record assembly and sample decode, one byte per transaction
module lsrp_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [lsrp_pkg::BYTE_W-1:0] rx_byte,
   input  logic                        restart,
   output lsrp_pkg::result_type        result
);
   import lsrp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic              desc_good_ff, desc_good_in;
   logic              first_seen_ff, first_seen_in;
   logic [BYTE_W-1:0] record_ff [RECORD_BUF];

   logic [IDX_W-1:0]  desc_idx;
   logic              desc_match;
   logic              record_done;
   logic              start_bit;
   logic              check_bit;

   // clamp as the descriptor index never runs past its last byte
   assign desc_idx    = (index_ff > IDX_W'(DESC_LAST)) ? IDX_W'(DESC_LAST) : index_ff;
   assign desc_match  = (rx_byte == desc_byte(desc_idx));
   assign record_done = (index_ff >= IDX_W'(RECORD_LAST));
   assign start_bit   = record_ff[0][0];
   assign check_bit   = record_ff[1][0];

   // next state
   always_comb begin
      phase_in      = phase_ff;
      index_in      = index_ff;
      desc_good_in  = desc_good_ff;
      first_seen_in = first_seen_ff;
      if (accept) begin
         if (restart) begin
            phase_in      = PHASE_DESC;
            index_in      = '0;
            desc_good_in  = 1'b1;
            first_seen_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PHASE_DESC: begin
                  if (!desc_match) begin
                     desc_good_in = 1'b0;
                  end
                  if (desc_idx == IDX_W'(DESC_LAST)) begin
                     index_in = '0;
                     phase_in = (desc_good_ff && desc_match) ? PHASE_REC : PHASE_HALT;
                  end else begin
                     index_in = desc_idx + IDX_W'(1);
                  end
               end
               PHASE_REC: begin
                  if (!record_done) begin
                     index_in = index_ff + IDX_W'(1);
                  end else begin
                     index_in = '0;
                     if (!first_seen_ff) begin
                        if (start_bit) begin
                           first_seen_in = 1'b1;
                        end else begin
                           phase_in = PHASE_HALT;
                        end
                     end else if (start_bit) begin
                        phase_in = PHASE_HALT;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // result of this transaction
   always_comb begin
      result             = '0;
      result.kind        = KIND_SAMPLE;
      if (accept && !restart) begin
         unique case (phase_ff)
            PHASE_DESC: begin
               if (desc_idx == IDX_W'(DESC_LAST) && !(desc_good_ff && desc_match)) begin
                  result.valid = 1'b1;
                  result.kind  = KIND_BAD_DESC;
               end
            end
            PHASE_REC: begin
               if (record_done) begin
                  if (!first_seen_ff && !start_bit) begin
                     result.valid = 1'b1;
                     result.kind  = KIND_NO_START;
                  end else if (first_seen_ff && start_bit) begin
                     result.valid = 1'b1;
                     result.kind  = KIND_REV_DONE;
                  end else if (check_bit) begin
                     result.valid       = 1'b1;
                     result.kind        = KIND_SAMPLE;
                     result.quality     = record_ff[0][BYTE_W-1:2];
                     result.angle_q6    = {record_ff[2], record_ff[1][BYTE_W-1:1]};
                     result.distance_q2 = {rx_byte, record_ff[3]};
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HALT;
         index_ff      <= '0;
         desc_good_ff  <= 1'b1;
         first_seen_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         index_ff      <= index_in;
         desc_good_ff  <= desc_good_in;
         first_seen_ff <= first_seen_in;
      end
   end

   // record buffer, no reset: each byte is written before the record completes
   always_ff @(posedge clock) begin
      if (accept && !restart && phase_ff == PHASE_REC && !record_done) begin
         record_ff[index_ff[1:0]] <= rx_byte;
      end
   end

endmodule

// ===== hw/rtl/lsrp_out_buf.sv =====
// result register with skid stage towards the result channel
module lsrp_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  lsrp_pkg::result_type push,
   output logic                 ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lsrp_pkg::result_type out_data
);
   import lsrp_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign ready     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = push;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== hw/rtl/lidar_scan_record_parser.sv =====
// top level of the lidar scan record parser
//
// req channel: one received serial byte per transaction in req_tdata; req_tuser
// set means restart, the byte is dropped and the parser waits for a new scan
// descriptor (A5 5A 05 00 00 40 81). after that, bytes are grouped into 5-byte
// sample records.
// rsp channel: rsp_tuser carries the kind (sample, descriptor mismatch, missing
// first start bit, revolution complete); rsp_tdata the decoded sample.
// results: only the 7th byte of a bad descriptor or a 5th record byte (unless
// its sample is dropped) gives one, registered in the result or skid register.
// throughput: one byte per cycle while the skid entry is free (req_tready high).
// reset: the parser is halted and ignores bytes until a restart transaction;
// no result is pending.
// stall: a result register plus a skid entry hold results while rsp_tready is
// low; req_tready drops only when both are full, so no result is lost
module lidar_scan_record_parser (
   input  logic                            clock,
   input  logic                            reset,
   // req: rx_byte [7:0]
   input  logic [lsrp_pkg::BYTE_W-1:0]     req_tdata,
   // req: restart [0]
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp: quality [5:0], angle_q6 [20:6], distance_q2 [36:21], zero fill [39:37]
   output logic [lsrp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp: kind [1:0]
   output logic [lsrp_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);
   import lsrp_pkg::*;

   logic       accept;
   result_type result;
   result_type out_data;

   // a byte is taken whenever the skid entry is free
   assign accept = req_tvalid && req_tready;

   lsrp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .restart (req_tuser),
      .result  (result)
   );

   lsrp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result),
      .ready     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // pack the sample fields, lowest field first
   assign rsp_tdata = {{(RSP_DATA_W - PAYLOAD_W){1'b0}},
                       out_data.distance_q2,
                       out_data.angle_q6,
                       out_data.quality};
   assign rsp_tuser = out_data.kind;

endmodule

// ===== bench/tb_lidar_scan_record_parser.sv =====
// self-checking bench for the lidar scan record parser: byte stream in, decoded samples out
module tb_lidar_scan_record_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import lsrp_pkg::*;

   // descriptor bytes, byte 0 in the lowest bits
   localparam logic [55:0] SCAN_DESC    = 56'h81_40_00_00_05_5A_A5;
   localparam int          RANDOM_BYTES = 1850;
   localparam int          IDLE_LIMIT   = 1000;   // cycles with no transaction on either side
   localparam int          DRAIN_LIMIT  = 500;
   localparam int          DRAIN_EVERY  = 600;    // sender waits for a quiet output this often

   // one pending byte for the req channel
   typedef struct packed {
      logic              restart;
      logic [BYTE_W-1:0] data;
      logic              drain;    // hold this byte until every expected result is out
   } rx_item_type;

   // one expected result transaction
   typedef struct packed {
      kind_type              kind;
      logic [QUALITY_W-1:0]  quality;
      logic [ANGLE_W-1:0]    angle_q6;
      logic [DISTANCE_W-1:0] distance_q2;
   } scan_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   rx_item_type     rx_queue[$];
   scan_result_type expected_results[$];

   // own copy of the parser state
   phase_type         scan_phase = PHASE_HALT;
   logic [IDX_W-1:0]  rx_pos     = '0;
   logic [BYTE_W-1:0] rec_buf [RECORD_BUF];
   logic              desc_ok    = 1'b1;
   logic              first_seen = 1'b0;

   int   errors      = 0;
   int   bytes_taken = 0;
   int   idle_cycles = 0;
   int   next_drain  = 0;
   int   kind_seen [4];
   logic steady;

   // no idling on either side through this stretch of the run
   assign steady = (bytes_taken >= 700) && (bytes_taken < 1000);

   lidar_scan_record_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),    // rx_byte [7:0]
      .req_tuser  (req_tuser),    // restart [0]
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),    // quality [5:0], angle_q6 [20:6], distance_q2 [36:21]
      .rsp_tuser  (rsp_tuser),    // kind [1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void push_result(kind_type kind, logic [QUALITY_W-1:0] q,
                                       logic [ANGLE_W-1:0] a, logic [DISTANCE_W-1:0] d);
      scan_result_type r;
      r.kind        = kind;
      r.quality     = q;
      r.angle_q6    = a;
      r.distance_q2 = d;
      expected_results.insert(expected_results.size(), r);
   endfunction

   // advances the parser state by one accepted byte and queues any result it gives
   function automatic void parse_byte(logic restart, logic [BYTE_W-1:0] rx);
      int p;
      p = rx_pos;
      if (restart) begin
         // restart wins in every phase, the byte itself is dropped
         scan_phase = PHASE_DESC;
         rx_pos     = '0;
         desc_ok    = 1'b1;
         first_seen = 1'b0;
         return;
      end
      case (scan_phase)
         PHASE_DESC: begin
            if (rx != SCAN_DESC[p*8 +: 8]) desc_ok = 1'b0;
            if (p == DESC_LAST) begin
               // a mismatch is only reported once all seven bytes are in
               rx_pos = '0;
               if (desc_ok) begin
                  scan_phase = PHASE_REC;
               end else begin
                  scan_phase = PHASE_HALT;
                  push_result(KIND_BAD_DESC, '0, '0, '0);
               end
            end else begin
               rx_pos = rx_pos + 1'b1;
            end
         end
         PHASE_REC: begin
            if (p < RECORD_LAST) begin
               rec_buf[p] = rx;
               rx_pos     = rx_pos + 1'b1;
            end else begin
               rx_pos = '0;
               if (!first_seen) begin
                  // first record of a scan must carry the start bit
                  if (!rec_buf[0][0]) begin
                     scan_phase = PHASE_HALT;
                     push_result(KIND_NO_START, '0, '0, '0);
                     return;
                  end
                  first_seen = 1'b1;
               end else if (rec_buf[0][0]) begin
                  // start bit again: one revolution done, no sample from this record
                  scan_phase = PHASE_HALT;
                  push_result(KIND_REV_DONE, '0, '0, '0);
                  return;
               end
               // check bit clear means the record is dropped
               if (rec_buf[1][0])
                  push_result(KIND_SAMPLE, rec_buf[0][7:2], {rec_buf[2], rec_buf[1][7:1]},
                              {rx, rec_buf[3]});
            end
         end
         default: begin
            // halted: bytes are ignored until a restart
         end
      endcase
   endfunction

   function automatic void push_rx(logic restart, logic [BYTE_W-1:0] data, logic drain);
      rx_item_type it;
      it.restart = restart;
      it.data    = data;
      it.drain   = drain;
      rx_queue.insert(rx_queue.size(), it);
   endfunction

   function automatic void push_desc();
      for (int i = 0; i <= DESC_LAST; i++) push_rx(1'b0, SCAN_DESC[i*8 +: 8], 1'b0);
   endfunction

   // sample record with the given start and check bits, cut short after len bytes
   function automatic void push_record(logic start, logic check, int len);
      logic [BYTE_W-1:0] b;
      for (int k = 0; k < len; k++) begin
         b = 8'($urandom);
         if (k == 0) b[0] = start;
         if (k == 1) b[0] = check;
         push_rx(1'b0, b, 1'b0);
      end
   endfunction

   // one scan with random content: mostly well formed, sometimes broken or cut short
   function automatic void add_scan();
      int                bad_pos;
      int                n_rec;
      logic              drain;
      logic [BYTE_W-1:0] b;
      // line noise ahead of the restart
      if ($urandom_range(0, 99) < 20)
         for (int i = $urandom_range(1, 3); i > 0; i--) push_rx(1'b0, 8'($urandom), 1'b0);
      drain = rx_queue.size() >= next_drain;
      if (drain) next_drain = next_drain + DRAIN_EVERY;
      push_rx(1'b1, 8'($urandom), drain);
      bad_pos = ($urandom_range(0, 99) < 12) ? $urandom_range(0, DESC_LAST) : -1;
      for (int i = 0; i <= DESC_LAST; i++) begin
         // descriptor abandoned part way, the next restart picks up
         if ($urandom_range(0, 99) < 1) return;
         b = SCAN_DESC[i*8 +: 8];
         if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
         push_rx(1'b0, b, 1'b0);
      end
      if (bad_pos >= 0) return;
      n_rec = $urandom_range(1, 8);
      for (int r = 0; r < n_rec; r++) begin
         if ($urandom_range(0, 99) < 3) begin
            push_record(1'b0, 1'b1, $urandom_range(1, 4));
            return;
         end
         push_record((r == 0) ? ($urandom_range(0, 99) < 90) : 1'b0,
                     $urandom_range(0, 99) < 85, 5);
      end
      if ($urandom_range(0, 99) < 85) push_record(1'b1, 1'($urandom_range(0, 1)), 5);
   endfunction

   // req driver: presents bytes from rx_queue, predicts each one as it is taken
   always @(posedge clock) begin : drive_req
      rx_item_type nxt;
      logic        load;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tuser, req_tdata);
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            load = rx_queue.size() != 0;
            if (load && rx_queue[0].drain && expected_results.size() != 0) load = 1'b0;
            if (load && !steady && $urandom_range(0, 99) < 10) load = 1'b0;
            if (load) begin
               nxt = rx_queue.pop_front();
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.restart;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   // rsp monitor: every result transaction against the oldest expectation
   always @(posedge clock) begin : watch_rsp
      scan_result_type       exp;
      logic [QUALITY_W-1:0]  q;
      logic [ANGLE_W-1:0]    a;
      logic [DISTANCE_W-1:0] d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         q = rsp_tdata[QUALITY_W-1:0];
         a = rsp_tdata[QUALITY_W +: ANGLE_W];
         d = rsp_tdata[QUALITY_W+ANGLE_W +: DISTANCE_W];
         kind_seen[rsp_tuser] = kind_seen[rsp_tuser] + 1;
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction: kind %0d", rsp_tuser);
            errors++;
         end else begin
            exp = expected_results.pop_front();
            if (rsp_tuser !== exp.kind) begin
               $error("kind: expected %0d, got %0d", exp.kind, rsp_tuser);
               errors++;
            end
            if (q !== exp.quality) begin
               $error("quality: expected %0d, got %0d", exp.quality, q);
               errors++;
            end
            if (a !== exp.angle_q6) begin
               $error("angle_q6: expected %0d, got %0d", exp.angle_q6, a);
               errors++;
            end
            if (d !== exp.distance_q2) begin
               $error("distance_q2: expected %0d, got %0d", exp.distance_q2, d);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int guard;
      for (int k = 0; k < 4; k++) kind_seen[k] = 0;
      for (int k = 0; k < RECORD_BUF; k++) rec_buf[k] = '0;

      // byte while halted after reset, ignored
      push_rx(1'b0, 8'hA5, 1'b0);
      // restart carrying an all-ones byte that must be dropped
      push_rx(1'b1, 8'hFF, 1'b0);
      push_desc();
      // first record with start and check: largest field values
      push_rx(1'b0, 8'hFF, 1'b0); push_rx(1'b0, 8'hFF, 1'b0); push_rx(1'b0, 8'hFF, 1'b0);
      push_rx(1'b0, 8'hFF, 1'b0); push_rx(1'b0, 8'hFF, 1'b0);
      // check bit only: all fields zero
      push_rx(1'b0, 8'h00, 1'b0); push_rx(1'b0, 8'h01, 1'b0); push_rx(1'b0, 8'h00, 1'b0);
      push_rx(1'b0, 8'h00, 1'b0); push_rx(1'b0, 8'h00, 1'b0);
      // check bit clear: record dropped
      push_rx(1'b0, 8'hFE, 1'b0); push_rx(1'b0, 8'hFE, 1'b0); push_rx(1'b0, 8'hFF, 1'b0);
      push_rx(1'b0, 8'hFF, 1'b0); push_rx(1'b0, 8'hFF, 1'b0);
      // second start bit closes the revolution
      push_rx(1'b0, 8'h03, 1'b0); push_rx(1'b0, 8'h01, 1'b0); push_rx(1'b0, 8'h00, 1'b0);
      push_rx(1'b0, 8'h00, 1'b0); push_rx(1'b0, 8'h00, 1'b0);
      // halted again
      push_rx(1'b0, 8'h5A, 1'b0);
      // descriptor wrong in its first byte: reported only after the seventh
      push_rx(1'b1, 8'h00, 1'b0);
      push_rx(1'b0, 8'h00, 1'b0); push_rx(1'b0, 8'h5A, 1'b0); push_rx(1'b0, 8'h05, 1'b0);
      push_rx(1'b0, 8'h00, 1'b0); push_rx(1'b0, 8'h00, 1'b0); push_rx(1'b0, 8'h40, 1'b0);
      push_rx(1'b0, 8'h81, 1'b0);
      // good descriptor, then a first record without its start bit
      push_rx(1'b1, 8'h81, 1'b0);
      push_desc();
      push_rx(1'b0, 8'h02, 1'b0); push_rx(1'b0, 8'h01, 1'b0); push_rx(1'b0, 8'h12, 1'b0);
      push_rx(1'b0, 8'h34, 1'b0); push_rx(1'b0, 8'h56, 1'b0);

      // random scans; the first restart waits for a quiet output
      next_drain = rx_queue.size();
      while (rx_queue.size() < RANDOM_BYTES) add_scan();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (rx_queue.size() != 0 || req_tvalid) @(posedge clock);
      guard = 0;
      while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      // wait on for anything the block might still send
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         errors += expected_results.size();
      end

      $display("run covered %0d bytes incl. restarts, noise and broken scans", bytes_taken);
      $display("results seen: %0d samples, %0d bad descriptors, %0d missing starts,",
               kind_seen[KIND_SAMPLE], kind_seen[KIND_BAD_DESC], kind_seen[KIND_NO_START]);
      $display("              %0d revolutions", kind_seen[KIND_REV_DONE]);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
